[rtl/ird_pkg.sv]
// Shared types, constants and helpers for the input-restricted deque.
package ird_pkg;

   // Storage geometry
   localparam int DEPTH       = 64;
   localparam int MAX_RESULTS = 64;
   localparam int PTR_W       = $clog2(DEPTH);
   localparam int CNT_W       = $clog2(DEPTH + 1);

   // Field widths
   localparam int DATA_W    = 32;
   localparam int CAP_W     = 7;
   localparam int OCC_OUT_W = 7;
   localparam int CMP_W     = (CNT_W > CAP_W) ? CNT_W : CAP_W;

   localparam logic [CAP_W-1:0] CAP_RESET = CAP_W'(64);

   // Command queue between front and back
   localparam int QUEUE_DEPTH = 4;
   localparam int QPTR_W      = $clog2(QUEUE_DEPTH);

   typedef enum logic [1:0] {
      CMD_INSERT    = 2'd0,
      CMD_DEL_FRONT = 2'd1,
      CMD_DEL_REAR  = 2'd2,
      CMD_DUMP      = 2'd3
   } command_type;

   typedef enum logic [1:0] {
      STAT_OK    = 2'd0,
      STAT_FULL  = 2'd1,
      STAT_EMPTY = 2'd2
   } status_type;

   typedef struct packed {
      command_type       kind;
      logic [DATA_W-1:0] data;
   } cmd_type;

   typedef struct packed {
      status_type           status;
      logic [DATA_W-1:0]    data;
      logic                 last;
      logic [OCC_OUT_W-1:0] occ;
   } result_type;

   // Wrap base + offset into the ring; offset is at most DEPTH
   function automatic logic [PTR_W-1:0] ring_index(input logic [PTR_W-1:0] base,
                                                   input logic [CNT_W-1:0] offset);
      logic [CNT_W:0] sum;
      sum = (CNT_W+1)'(base) + (CNT_W+1)'(offset);
      if (sum >= (CNT_W+1)'(DEPTH)) begin
         sum = sum - (CNT_W+1)'(DEPTH);
      end
      return sum[PTR_W-1:0];
   endfunction

endpackage

[rtl/input_restricted_deque_top.sv]
// Top level of the input-restricted deque: front stage, command queue, execution unit.
//
// Usage: a bounded deque of signed 32-bit words in a ring buffer of DEPTH entries.
// req channel: one command beat (tuser = command, tdata = word to insert).
// rsp channel: result beats (tuser = status, tdata = word and occupancy, tlast marks
// the final beat of a command). csr channel: writes the capacity limit; always ready.
// The user must write it only while no command is in flight; the block does not enforce this.
// Path: with empty queues a command beat passes the front register, the command queue
// and execution into the result register.
// Throughput: insert and delete sustain one command per cycle while rsp is not stalled.
// A dump gives one beat per stored word, with a read state and an emit state per word,
// set by the registered read port of the storage; no new command is taken until it ends.
// Reset empties the deque, zeroes the head pointer and sets capacity to 64; no
// clearing pass is needed. A stalled rsp channel holds the current beat; the
// four-entry command queue and the front register keep accepting until they fill,
// then req_tready drops.
module input_restricted_deque_top
   import ird_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [1:0]  req_tuser,   // [1:0] command
   input  logic [31:0] req_tdata,   // [31:0] data_in
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [1:0]  rsp_tuser,   // [1:0] status
   output logic [39:0] rsp_tdata,   // [31:0] data_out, [38:32] occupancy_out, [39] zero
   output logic        rsp_tlast,
   input  logic        csr_tvalid,
   output logic        csr_tready,
   input  logic [7:0]  csr_tdata    // [6:0] capacity, [7] unused
);

   logic       push_valid, push_ready;
   cmd_type    push_cmd;
   logic       pop_valid, pop_ready;
   cmd_type    pop_cmd;
   result_type result;

   assign csr_tready = 1'b1;

   ird_front u_front (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tuser  (req_tuser),
      .req_tdata  (req_tdata),
      .push_valid (push_valid),
      .push_ready (push_ready),
      .push_cmd   (push_cmd)
   );

   ird_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push_valid (push_valid),
      .push_ready (push_ready),
      .push_cmd   (push_cmd),
      .pop_valid  (pop_valid),
      .pop_ready  (pop_ready),
      .pop_cmd    (pop_cmd)
   );

   ird_back u_back (
      .clock        (clock),
      .reset        (reset),
      .csr_tvalid   (csr_tvalid),
      .csr_capacity (csr_tdata[CAP_W-1:0]),
      .pop_valid    (pop_valid),
      .pop_ready    (pop_ready),
      .pop_cmd      (pop_cmd),
      .rsp_valid    (rsp_tvalid),
      .rsp_ready    (rsp_tready),
      .rsp_result   (result)
   );

   // Pack the result beat
   assign rsp_tuser = result.status;
   assign rsp_tlast = result.last;
   assign rsp_tdata = {1'b0, result.occ, result.data};

endmodule

[rtl/ird_front.sv]
// Front stage: registers incoming command beats and classifies them.
module ird_front
   import ird_pkg::*;
(
   input  logic              clock,
   input  logic              reset,
   input  logic              req_tvalid,
   output logic              req_tready,
   input  logic [1:0]        req_tuser,
   input  logic [DATA_W-1:0] req_tdata,
   output logic              push_valid,
   input  logic              push_ready,
   output cmd_type           push_cmd
);

   logic    valid_ff, valid_in;
   cmd_type cmd_ff, cmd_in;

   assign req_tready = !valid_ff || push_ready;
   assign push_valid = valid_ff;
   assign push_cmd   = cmd_ff;

   // Decode the beat; drop the data word for anything but an insert
   always_comb begin
      cmd_in.kind = command_type'(req_tuser);
      cmd_in.data = (command_type'(req_tuser) == CMD_INSERT) ? req_tdata : '0;
      valid_in    = valid_ff;
      if (req_tvalid && req_tready) begin
         valid_in = 1'b1;
      end else if (push_ready) begin
         valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_tvalid && req_tready) begin
         cmd_ff <= cmd_in;
      end
   end

endmodule

[rtl/ird_queue.sv]
// Short command queue that decouples the front stage from the execution unit.
module ird_queue
   import ird_pkg::*;
(
   input  logic    clock,
   input  logic    reset,
   input  logic    push_valid,
   output logic    push_ready,
   input  cmd_type push_cmd,
   output logic    pop_valid,
   input  logic    pop_ready,
   output cmd_type pop_cmd
);

   cmd_type             slot_ff [QUEUE_DEPTH];
   logic [QPTR_W-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [QPTR_W-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [QPTR_W:0]     count_ff, count_in;
   logic                push, pop;

   assign push_ready = (count_ff != (QPTR_W+1)'(QUEUE_DEPTH));
   assign pop_valid  = (count_ff != '0);
   assign pop_cmd    = slot_ff[rd_ptr_ff];
   assign push       = push_valid && push_ready;
   assign pop        = pop_valid && pop_ready;

   // Advance pointers and track fill level
   always_comb begin
      wr_ptr_in = push ? wr_ptr_ff + 1'b1 : wr_ptr_ff;
      rd_ptr_in = pop ? rd_ptr_ff + 1'b1 : rd_ptr_ff;
      count_in  = count_ff;
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         slot_ff[wr_ptr_ff] <= push_cmd;
      end
   end

endmodule

[rtl/ird_back.sv]
// Execution unit: ring-buffer storage, command execution and result register.
module ird_back
   import ird_pkg::*;
(
   input  logic             clock,
   input  logic             reset,
   input  logic             csr_tvalid,
   input  logic [CAP_W-1:0] csr_capacity,
   input  logic             pop_valid,
   output logic             pop_ready,
   input  cmd_type          pop_cmd,
   output logic             rsp_valid,
   input  logic             rsp_ready,
   output result_type       rsp_result
);

   typedef enum logic [2:0] {
      ST_IDLE = 3'b001,
      ST_READ = 3'b010,
      ST_EMIT = 3'b100
   } state_type;

   state_type           state_ff, state_in;
   logic [PTR_W-1:0]    head_ff, head_in;
   logic [CNT_W-1:0]    occ_ff, occ_in;
   logic [CNT_W-1:0]    idx_ff, idx_in;
   logic [CNT_W-1:0]    cnt_ff, cnt_in;
   logic [CAP_W-1:0]    cap_ff;
   logic [DATA_W-1:0]   mem [DEPTH];
   logic [DATA_W-1:0]   rd_data_ff;
   logic                rsp_valid_ff;
   result_type          rsp_ff, out_in;
   logic                out_load, out_free;
   logic                mem_we, rd_en;
   logic [PTR_W-1:0]    wr_addr, rd_addr;
   logic [CMP_W-1:0]    limit;
   logic                full;
   logic [CNT_W-1:0]    dump_cnt;
   logic                dump_last;

   assign out_free   = !rsp_valid_ff || rsp_ready;
   assign rsp_valid  = rsp_valid_ff;
   assign rsp_result = rsp_ff;

   assign limit = (CMP_W'(cap_ff) > CMP_W'(DEPTH)) ? CMP_W'(DEPTH) : CMP_W'(cap_ff);
   assign full  = (CMP_W'(occ_ff) >= limit);
   assign dump_cnt  = (32'(occ_ff) > MAX_RESULTS) ? CNT_W'(MAX_RESULTS) : occ_ff;
   assign dump_last = ((idx_ff + 1'b1) == cnt_ff);
   assign wr_addr   = ring_index(head_ff, occ_ff);
   assign rd_addr   = ring_index(head_ff, idx_ff);

   // Execute one command, or step a dump one element at a time
   always_comb begin
      state_in  = state_ff;
      head_in   = head_ff;
      occ_in    = occ_ff;
      idx_in    = idx_ff;
      cnt_in    = cnt_ff;
      pop_ready = 1'b0;
      mem_we    = 1'b0;
      rd_en     = 1'b0;
      out_load  = 1'b0;
      out_in.status = STAT_OK;
      out_in.data   = '0;
      out_in.last   = 1'b1;
      out_in.occ    = '0;
      case (state_ff)
         ST_IDLE: begin
            if (pop_valid && out_free) begin
               pop_ready = 1'b1;
               out_load  = 1'b1;
               case (pop_cmd.kind)
                  CMD_INSERT: begin
                     if (full) begin
                        out_in.status = STAT_FULL;
                     end else begin
                        mem_we = 1'b1;
                        occ_in = occ_ff + 1'b1;
                     end
                  end
                  CMD_DEL_FRONT: begin
                     if (occ_ff == '0) begin
                        out_in.status = STAT_EMPTY;
                     end else begin
                        head_in = ring_index(head_ff, CNT_W'(1));
                        occ_in  = occ_ff - 1'b1;
                     end
                  end
                  CMD_DEL_REAR: begin
                     if (occ_ff == '0) begin
                        out_in.status = STAT_EMPTY;
                     end else begin
                        occ_in = occ_ff - 1'b1;
                     end
                  end
                  CMD_DUMP: begin
                     if (occ_ff == '0) begin
                        out_in.status = STAT_EMPTY;
                     end else begin
                        out_load = 1'b0;
                        idx_in   = '0;
                        cnt_in   = dump_cnt;
                        state_in = ST_READ;
                     end
                  end
                  default: begin
                     out_in.status = STAT_EMPTY;
                  end
               endcase
               out_in.occ = OCC_OUT_W'(occ_in);
            end
         end
         ST_READ: begin
            rd_en    = 1'b1;
            state_in = ST_EMIT;
         end
         ST_EMIT: begin
            if (out_free) begin
               out_load    = 1'b1;
               out_in.data = rd_data_ff;
               out_in.last = dump_last;
               out_in.occ  = OCC_OUT_W'(occ_ff);
               idx_in      = idx_ff + 1'b1;
               state_in    = dump_last ? ST_IDLE : ST_READ;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // Hold control state and the capacity register
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         head_ff      <= '0;
         occ_ff       <= '0;
         idx_ff       <= '0;
         cnt_ff       <= '0;
         cap_ff       <= CAP_RESET;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         head_ff  <= head_in;
         occ_ff   <= occ_in;
         idx_ff   <= idx_in;
         cnt_ff   <= cnt_in;
         if (csr_tvalid) begin
            cap_ff <= csr_capacity;
         end
         if (out_load) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   // Result payload
   always_ff @(posedge clock) begin
      if (out_load) begin
         rsp_ff <= out_in;
      end
   end

   // Entry storage: one write port, one registered read port
   always_ff @(posedge clock) begin
      if (mem_we) begin
         mem[wr_addr] <= pop_cmd.data;
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

endmodule

[rtl/ird_checker.sv]
// Port-level checks for the deque top level, attached by bind.
module ird_checker
   import ird_pkg::*;
(
   input logic        clock,
   input logic        reset,
   input logic        rsp_tvalid,
   input logic        rsp_tready,
   input logic [1:0]  rsp_tuser,
   input logic [39:0] rsp_tdata,
   input logic        rsp_tlast
);

   // Refused or empty commands give a single zero-data beat
   a_error_single: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && rsp_tuser != STAT_OK) |-> (rsp_tlast && rsp_tdata[31:0] == '0))
      else $error("non-success result is not a single zero beat");

   // Reported occupancy never exceeds the storage depth
   a_occ_bound: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> (32'(rsp_tdata[38:32]) <= DEPTH))
      else $error("occupancy above depth");

   // An empty status reports an empty deque
   a_empty_occ: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && rsp_tuser == STAT_EMPTY) |-> (rsp_tdata[38:32] == '0))
      else $error("empty status with nonzero occupancy");

   // Within a dump the occupancy stays fixed across beats
   a_dump_occ: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && rsp_tready && !rsp_tlast) |=>
         (!rsp_tvalid || rsp_tdata[38:32] == $past(rsp_tdata[38:32])))
      else $error("occupancy changed inside a dump");

   // A stalled beat holds
   a_hold: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && !rsp_tready) |=> (rsp_tvalid && $stable(rsp_tdata)))
      else $error("stalled result beat changed");

endmodule

bind input_restricted_deque_top ird_checker u_ird_checker (
   .clock      (clock),
   .reset      (reset),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tuser  (rsp_tuser),
   .rsp_tdata  (rsp_tdata),
   .rsp_tlast  (rsp_tlast)
);

[dv/deque_checker.sv]
`timescale 1ns / 1ps
// Checker for the deque: watches all three channels, predicts result beats, compares them.
module deque_checker
   import ird_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   input  logic        req_tready,
   input  logic [1:0]  req_tuser,   // [1:0] command
   input  logic [31:0] req_tdata,   // [31:0] data_in
   input  logic        rsp_tvalid,
   input  logic        rsp_tready,
   input  logic [1:0]  rsp_tuser,   // [1:0] status
   input  logic [39:0] rsp_tdata,   // [31:0] data_out, [38:32] occupancy_out, [39] zero
   input  logic        rsp_tlast,
   input  logic        csr_tvalid,
   input  logic        csr_tready,
   input  logic [7:0]  csr_tdata,   // [6:0] capacity, [7] unused
   output int          fail_count,
   output int          pending_count,
   output int          beat_count
);

   // Shadow copy of the deque and its capacity register
   logic [DATA_W-1:0] word_store [DEPTH];
   logic [PTR_W-1:0]  front_ptr;
   int                stored;
   logic [CAP_W-1:0]  cap_limit;
   result_type        pending_results [$];

   // Print one line per mismatch; keep the log short once things go badly wrong
   task automatic report_mismatch(input string what, input logic [63:0] got,
                                  input logic [63:0] want);
      if (fail_count < 40) begin
         $display("MISMATCH %s: got %0h, want %0h at %0t", what, got, want, $time);
      end
      fail_count++;
   endtask

   // Queue one expected beat, tagged with the occupancy after the command
   task automatic queue_result(input status_type st, input logic [DATA_W-1:0] word,
                               input logic is_last);
      result_type r;
      r.status = st;
      r.data   = word;
      r.last   = is_last;
      r.occ    = OCC_OUT_W'(stored);
      pending_results.push_back(r);
   endtask

   // Apply one command to the shadow deque and queue the beats it must produce
   task automatic apply_command(input command_type cmd, input logic [DATA_W-1:0] word);
      int limit;
      int count;
      limit = (int'(cap_limit) > DEPTH) ? DEPTH : int'(cap_limit);
      case (cmd)
         CMD_INSERT: begin
            if (stored >= limit) begin
               queue_result(STAT_FULL, '0, 1'b1);
            end else begin
               word_store[(int'(front_ptr) + stored) % DEPTH] = word;
               stored++;
               queue_result(STAT_OK, '0, 1'b1);
            end
         end
         CMD_DEL_FRONT: begin
            if (stored == 0) begin
               queue_result(STAT_EMPTY, '0, 1'b1);
            end else begin
               front_ptr = PTR_W'((int'(front_ptr) + 1) % DEPTH);
               stored--;
               queue_result(STAT_OK, '0, 1'b1);
            end
         end
         CMD_DEL_REAR: begin
            if (stored == 0) begin
               queue_result(STAT_EMPTY, '0, 1'b1);
            end else begin
               stored--;
               queue_result(STAT_OK, '0, 1'b1);
            end
         end
         default: begin
            if (stored == 0) begin
               queue_result(STAT_EMPTY, '0, 1'b1);
            end else begin
               count = (stored > MAX_RESULTS) ? MAX_RESULTS : stored;
               for (int k = 0; k < count; k++) begin
                  queue_result(STAT_OK, word_store[(int'(front_ptr) + k) % DEPTH],
                               k == count - 1);
               end
            end
         end
      endcase
   endtask

   // Sample every handshake at the rising edge
   always @(posedge clock) begin
      result_type want;
      if (reset) begin
         front_ptr  = '0;
         stored     = 0;
         cap_limit  = CAP_RESET;
         fail_count = 0;
         beat_count = 0;
         pending_results.delete();
      end else begin
         if (csr_tvalid && csr_tready) begin
            cap_limit = csr_tdata[CAP_W-1:0];
         end
         if (req_tvalid && req_tready) begin
            apply_command(command_type'(req_tuser), req_tdata);
         end
         if (rsp_tvalid && rsp_tready) begin
            beat_count++;
            if (pending_results.size() == 0) begin
               report_mismatch("beat with no result expected", 64'(rsp_tdata), '0);
            end else begin
               want = pending_results.pop_front();
               if (rsp_tuser !== want.status) begin
                  report_mismatch("status", 64'(rsp_tuser), 64'(want.status));
               end
               if (rsp_tdata[31:0] !== want.data) begin
                  report_mismatch("data_out", 64'(rsp_tdata[31:0]), 64'(want.data));
               end
               if (rsp_tlast !== want.last) begin
                  report_mismatch("last", 64'(rsp_tlast), 64'(want.last));
               end
               if (rsp_tdata[38:32] !== want.occ) begin
                  report_mismatch("occupancy_out", 64'(rsp_tdata[38:32]), 64'(want.occ));
               end
            end
         end
      end
      pending_count = pending_results.size();
   end

endmodule

[dv/testbench.sv]
`timescale 1ns / 1ps
// Testbench top for the deque: clock, reset, command and capacity stimulus, verdict.
module testbench
   import ird_pkg::*;
();

   logic        clock;
   logic        reset;
   logic        req_tvalid;
   logic        req_tready;
   logic [1:0]  req_tuser;
   logic [31:0] req_tdata;
   logic        rsp_tvalid;
   logic        rsp_tready;
   logic [1:0]  rsp_tuser;
   logic [39:0] rsp_tdata;
   logic        rsp_tlast;
   logic        csr_tvalid;
   logic        csr_tready;
   logic [7:0]  csr_tdata;

   int   send_idle_pct = 0;
   int   rsp_stall_pct = 0;
   bit   rsp_hold      = 1'b0;
   event hold_go;
   int   commands_sent = 0;
   int   fail_count;
   int   pending_count;
   int   beat_count;

   // 10 ns clock
   always begin
      clock = 1'b0;
      #5;
      clock = 1'b1;
      #5;
   end

   input_restricted_deque_top dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tuser  (req_tuser),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tuser  (rsp_tuser),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast),
      .csr_tvalid (csr_tvalid),
      .csr_tready (csr_tready),
      .csr_tdata  (csr_tdata)
   );

   deque_checker u_checker (
      .clock         (clock),
      .reset         (reset),
      .req_tvalid    (req_tvalid),
      .req_tready    (req_tready),
      .req_tuser     (req_tuser),
      .req_tdata     (req_tdata),
      .rsp_tvalid    (rsp_tvalid),
      .rsp_tready    (rsp_tready),
      .rsp_tuser     (rsp_tuser),
      .rsp_tdata     (rsp_tdata),
      .rsp_tlast     (rsp_tlast),
      .csr_tvalid    (csr_tvalid),
      .csr_tready    (csr_tready),
      .csr_tdata     (csr_tdata),
      .fail_count    (fail_count),
      .pending_count (pending_count),
      .beat_count    (beat_count)
   );

   // Receiver: random stalls, or a solid hold-off while one is running
   initial begin
      rsp_tready = 1'b0;
      forever begin
         @(negedge clock);
         if (rsp_hold) begin
            rsp_tready <= 1'b0;
         end else begin
            rsp_tready <= ($urandom_range(0, 99) >= rsp_stall_pct);
         end
      end
   end

   // Long receiver hold-off, counted here so the sender keeps pushing meanwhile
   initial begin
      forever begin
         @(hold_go);
         rsp_hold = 1'b1;
         repeat (300) @(negedge clock);
         rsp_hold = 1'b0;
      end
   end

   // Run limit
   initial begin
      #5_000_000;
      $display("testbench failed");
      $finish;
   end

   // Mostly random words, with the extremes mixed in
   function automatic logic [31:0] rand_word();
      case ($urandom_range(0, 7))
         0:       return 32'h8000_0000;
         1:       return 32'h7FFF_FFFF;
         2:       return 32'h0000_0000;
         3:       return 32'hFFFF_FFFF;
         default: return $urandom();
      endcase
   endfunction

   // Offer one command beat, with random sender gaps, and hold it until accepted
   task automatic send_command(input command_type cmd, input logic [31:0] word);
      while ($urandom_range(0, 99) < send_idle_pct) begin
         req_tvalid <= 1'b0;
         @(negedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser  <= cmd;
      req_tdata  <= word;
      do @(posedge clock); while (req_tready !== 1'b1);
      commands_sent++;
      @(negedge clock);
   endtask

   // Stop sending and wait until every expected beat has come back
   task automatic drain();
      req_tvalid <= 1'b0;
      while (pending_count != 0) @(negedge clock);
   endtask

   // Write the capacity register once the deque is idle; bit 7 is don't-care
   task automatic write_capacity(input logic [6:0] cap);
      drain();
      repeat (4) @(negedge clock);
      csr_tvalid <= 1'b1;
      csr_tdata  <= {1'($urandom_range(0, 1)), cap};
      do @(posedge clock); while (csr_tready !== 1'b1);
      @(negedge clock);
      csr_tvalid <= 1'b0;
   endtask

   // Random command mix: ins_pct inserts, dump_pct dumps, the rest split between deletes
   task automatic run_random(input int n, input int ins_pct, input int dump_pct);
      int          r;
      command_type cmd;
      for (int i = 0; i < n; i++) begin
         r = $urandom_range(0, 99);
         if (r < ins_pct) begin
            cmd = CMD_INSERT;
         end else if (r < ins_pct + dump_pct) begin
            cmd = CMD_DUMP;
         end else if ($urandom_range(0, 1) == 0) begin
            cmd = CMD_DEL_FRONT;
         end else begin
            cmd = CMD_DEL_REAR;
         end
         send_command(cmd, rand_word());
      end
   endtask

   initial begin
      reset      = 1'b1;
      req_tvalid = 1'b0;
      req_tuser  = CMD_INSERT;
      req_tdata  = '0;
      csr_tvalid = 1'b0;
      csr_tdata  = '0;
      repeat (4) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // Empty deque: dump and both deletes report empty
      send_command(CMD_DUMP, rand_word());
      send_command(CMD_DEL_FRONT, rand_word());
      send_command(CMD_DEL_REAR, rand_word());
      // Extreme words, then dump and single-result deletes
      send_command(CMD_INSERT, 32'h8000_0000);
      send_command(CMD_INSERT, 32'h7FFF_FFFF);
      send_command(CMD_INSERT, 32'h0000_0000);
      send_command(CMD_INSERT, 32'hFFFF_FFFF);
      send_command(CMD_DUMP, rand_word());
      send_command(CMD_DEL_FRONT, rand_word());
      send_command(CMD_DEL_REAR, rand_word());
      send_command(CMD_DUMP, rand_word());

      // Capacity lowered below the two stored words
      write_capacity(7'd1);
      send_command(CMD_INSERT, rand_word());
      send_command(CMD_DUMP, rand_word());
      send_command(CMD_DEL_FRONT, rand_word());
      send_command(CMD_DEL_FRONT, rand_word());
      send_command(CMD_INSERT, rand_word());
      send_command(CMD_INSERT, rand_word());
      send_command(CMD_DUMP, rand_word());

      // Capacity zero refuses every insert
      write_capacity(7'd0);
      send_command(CMD_INSERT, rand_word());
      send_command(CMD_DEL_REAR, rand_word());
      send_command(CMD_INSERT, rand_word());
      send_command(CMD_DEL_REAR, rand_word());

      // Capacity above depth saturates: fill past full, then a full-depth dump
      write_capacity(7'd127);
      for (int i = 0; i < 70; i++) begin
         send_command(CMD_INSERT, rand_word());
      end
      send_command(CMD_DUMP, rand_word());
      run_random(20, 50, 10);

      // Sender gaps
      write_capacity(7'd64);
      send_idle_pct = 78;
      run_random(60, 40, 15);

      // Receiver stalls
      write_capacity(7'd40);
      send_idle_pct = 0;
      rsp_stall_pct = 78;
      run_random(60, 55, 10);

      // Both sides idle
      write_capacity(7'd3);
      send_idle_pct = 28;
      rsp_stall_pct = 28;
      run_random(50, 50, 15);

      // Back-pressure: receiver holds off while the sender keeps offering
      write_capacity(7'd64);
      send_idle_pct = 0;
      rsp_stall_pct = 0;
      -> hold_go;
      run_random(40, 60, 10);

      // Pause until everything is back, then a small capacity to finish
      drain();
      write_capacity(7'd1);
      rsp_stall_pct = 28;
      run_random(20, 50, 20);

      drain();
      repeat (20) @(negedge clock);
      $display("Covered %0d commands and %0d result beats: empty and full deque,",
               commands_sent, beat_count);
      $display("capacity 0 to 127, full-depth dumps, gaps, stalls and a long hold-off.");
      if (fail_count == 0) begin
         $display("testbench passed");
      end else begin
         $display("testbench failed");
      end
      $finish;
   end

endmodule
